// ===== hw/rtl/tvf_pkg.sv =====
`default_nettype none
package tvf_pkg;
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_U8  = 4'd1;
   localparam logic [3:0] OP_I8  = 4'd2;
   localparam logic [3:0] OP_U16 = 4'd3;
   localparam logic [3:0] OP_I16 = 4'd4;
   localparam logic [3:0] OP_U32 = 4'd5;
   localparam logic [3:0] OP_I32 = 4'd6;
   localparam logic [3:0] OP_U64 = 4'd7;
   localparam logic [3:0] OP_I64 = 4'd8;
   localparam logic [3:0] OP_F32 = 4'd9;
   localparam logic [3:0] OP_F64 = 4'd10;

   localparam logic [31:0] F32_ZERO = 32'h0000_0000;
   localparam logic [30:0] F32_INF  = 31'h7F80_0000;
   localparam logic [30:0] F32_QNAN = 31'h7FC0_0000;

   // how stage 1 hands an item to the normalizer
   typedef enum logic [1:0] {
      KIND_FIXED = 2'd0,  // result already known
      KIND_INT   = 2'd1,  // integer magnitude, normalize and round
      KIND_DBL   = 2'd2   // finite normal double, round
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        sign;
      logic [63:0] mag;     // integer magnitude or double mantissa (53 bits)
      logic [10:0] dexp;    // biased double exponent
      logic [31:0] fixed;
   } dec_type;

   typedef struct packed {
      kind_type    kind;
      logic        sign;
      logic [63:0] norm;    // leading one in bit 63 (integers)
      logic [6:0]  lz;
      logic [10:0] dexp;
      logic [31:0] fixed;
   } nrm_type;
endpackage
`default_nettype wire

// ===== hw/rtl/typed_value_to_float32.sv =====
`default_nettype none
// typed_value_to_float32: converts a typed value (8/16/32/64-bit signed or
// unsigned integer, float32 pass-through, float64 narrowing) given as
// big-endian bytes into an IEEE-754 single bit pattern, rounding to nearest
// even. Short lengths, length zero and unknown type codes give +0.0.
// Three register stages (decode, normalize, round); the round stage register
// is the output register. An item enters every cycle while req_ready is high;
// an accepted item passes through the decode, normalize and round registers
// to rsp_valid. Stalls hold the whole pipe; a bubble is filled when a later
// stage is free, so req_ready stays high while any stage is empty.
module typed_value_to_float32 import tvf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_op,
   input  wire logic [63:0] req_value_bytes,
   input  wire logic [7:0]  req_byte_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_float_bits
);
   dec_type     dec_in, dec_ff;
   nrm_type     nrm_in, nrm_ff;
   logic [31:0] res_in, res_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic        en1, en2, en3;

   // each stage advances when its downstream holder is empty or moving
   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   tvf_decode u_decode (
      .op(req_op), .value_bytes(req_value_bytes), .byte_count(req_byte_count),
      .dec(dec_in)
   );
   tvf_normalize u_normalize (.dec(dec_ff), .nrm(nrm_in));
   tvf_round u_round (.nrm(nrm_ff), .float_bits(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) dec_ff <= dec_in;
      if (en2) nrm_ff <= nrm_in;
      if (en3) res_ff <= res_in;
   end

   assign rsp_valid      = v3_ff;
   assign rsp_float_bits = res_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/tvf_decode.sv =====
`default_nettype none
module tvf_decode import tvf_pkg::*; (
   input  wire logic [3:0]  op,
   input  wire logic [63:0] value_bytes,
   input  wire logic [7:0]  byte_count,
   output dec_type          dec
);
   logic [63:0] raw;
   logic        sgn;
   logic        known;
   logic [3:0]  need;

   always_comb begin
      raw   = '0;
      sgn   = 1'b0;
      known = 1'b1;
      need  = 4'd1;
      dec   = '{kind: KIND_FIXED, sign: 1'b0, mag: '0, dexp: '0, fixed: F32_ZERO};
      case (op)
         OP_U8:  raw = {56'd0, value_bytes[63:56]};
         OP_I8:  begin
            sgn = value_bytes[63];
            raw = sgn ? {56'd0, 8'(-value_bytes[63:56])} : {56'd0, value_bytes[63:56]};
         end
         OP_U16: begin
            need = 4'd2;
            raw  = {48'd0, value_bytes[63:48]};
         end
         OP_I16: begin
            need = 4'd2;
            sgn  = value_bytes[63];
            raw  = sgn ? {48'd0, 16'(-value_bytes[63:48])} : {48'd0, value_bytes[63:48]};
         end
         OP_U32, OP_F32: begin
            need = 4'd4;
            raw  = {32'd0, value_bytes[63:32]};
         end
         OP_I32: begin
            need = 4'd4;
            sgn  = value_bytes[63];
            raw  = sgn ? {32'd0, 32'(-value_bytes[63:32])} : {32'd0, value_bytes[63:32]};
         end
         OP_U64, OP_F64: begin
            need = 4'd8;
            raw  = value_bytes;
         end
         OP_I64: begin
            need = 4'd8;
            sgn  = value_bytes[63];
            raw  = sgn ? -value_bytes : value_bytes;
         end
         default: known = 1'b0;
      endcase

      if (known && byte_count != 8'd0 && byte_count >= {4'd0, need}) begin
         if (op == OP_F32) begin
            dec.fixed = raw[31:0];
         end else if (op == OP_F64) begin
            dec.sign = raw[63];
            dec.fixed = {raw[63], 31'd0};
            if (raw[62:52] == 11'h7FF) begin
               if (raw[51:0] == '0) dec.fixed = {raw[63], F32_INF};
               else dec.fixed = {raw[63], F32_QNAN | {8'd0, raw[51:29]}};
            end else if (raw[62:52] != 11'd0) begin
               dec.kind = KIND_DBL;
               dec.mag  = {11'd0, 1'b1, raw[51:0]};
               dec.dexp = raw[62:52];
            end
         end else if (raw != '0) begin
            dec.kind = KIND_INT;
            dec.sign = sgn;
            dec.mag  = raw;
         end
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tvf_normalize.sv =====
`default_nettype none
module tvf_normalize import tvf_pkg::*; (
   input  wire dec_type dec,
   output nrm_type      nrm
);
   logic [5:0] lz;

   // leading zero count over the 64-bit magnitude
   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (dec.mag[i]) lz = 6'(63 - i);
      end
   end

   always_comb begin
      nrm.kind  = dec.kind;
      nrm.sign  = dec.sign;
      nrm.dexp  = dec.dexp;
      nrm.fixed = dec.fixed;
      nrm.lz    = {1'b0, lz};
      nrm.norm  = (dec.kind == KIND_INT) ? (dec.mag << lz) : dec.mag;
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tvf_round.sv =====
`default_nettype none
module tvf_round import tvf_pkg::*; (
   input  wire nrm_type      nrm,
   output logic [31:0]       float_bits
);
   logic [24:0] keep;
   logic        rbit;
   logic        stk;
   logic [7:0]  iexp;
   logic signed [12:0] ex;
   logic signed [12:0] shw;
   logic [6:0]  sh;
   logic [116:0] wide;
   logic [63:0] drop;
   logic [24:0] dk;
   logic        dhalf;
   logic        dsticky;

   always_comb begin
      float_bits = nrm.fixed;
      keep = '0; rbit = 1'b0; stk = 1'b0; iexp = '0;
      ex = '0; shw = '0; sh = '0; wide = '0; drop = '0; dk = '0;
      dhalf = 1'b0; dsticky = 1'b0;
      case (nrm.kind)
         KIND_INT: begin
            keep = {1'b0, nrm.norm[63:40]};
            rbit = nrm.norm[39];
            stk  = |nrm.norm[38:0];
            if (rbit && (stk || keep[0])) keep = keep + 25'd1;
            iexp = 8'(8'd190 - {1'b0, nrm.lz});
            if (keep[24]) begin
               iexp = iexp + 8'd1;
               keep = keep >> 1;
            end
            float_bits = {nrm.sign, iexp, keep[22:0]};
         end
         KIND_DBL: begin
            ex = $signed({2'b0, nrm.dexp}) - 13'sd1023;
            if (ex > 13'sd127) begin
               float_bits = {nrm.sign, F32_INF};
            end else if (ex >= -13'sd126) begin
               keep = {1'b0, nrm.norm[52:29]};
               rbit = nrm.norm[28];
               stk  = |nrm.norm[27:0];
               if (rbit && (stk || keep[0])) keep = keep + 25'd1;
               if (keep[24]) begin
                  keep = keep >> 1;
                  ex = ex + 13'sd1;
               end
               if (ex > 13'sd127) float_bits = {nrm.sign, F32_INF};
               else float_bits = {nrm.sign, 8'(ex + 13'sd127), keep[22:0]};
            end else begin
               // full-width shift count: tiny exponents reach several hundred
               shw = -ex - 13'sd97;
               if (shw > 13'sd60) begin
                  float_bits = {nrm.sign, 31'd0};
               end else begin
                  sh = 7'(shw);
                  wide = {nrm.norm, 53'd0} >> sh;
                  dk = 25'(wide[116:53]);
                  dhalf = wide[52];
                  dsticky = |wide[51:0];
                  if (dhalf && (dsticky || dk[0])) dk = dk + 25'd1;
                  float_bits = {nrm.sign, 7'd0, dk[23:0]};
               end
            end
         end
         default: float_bits = nrm.fixed;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/tvf_checker.sv =====
`default_nettype none
module tvf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_float_bits
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_float_bits))
      else $error("rsp item dropped or changed while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output empty");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |-> rsp_valid)
      else $error("item not delivered after pipeline latency");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind typed_value_to_float32 tvf_checker u_tvf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_float_bits(rsp_float_bits)
);
`default_nettype wire

// ===== tb/sv/tvf_checker.sv =====
module tvf_scoreboard import tvf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [3:0]  req_op,
   input  logic [63:0] req_value_bytes,
   input  logic [7:0]  req_byte_count,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_float_bits,
   output int          fail_count,
   output int          pending
);
   logic [31:0] expected_bits[$];

   function automatic logic [63:0] rne_shift(input logic [63:0] v, input int sh);
      logic [63:0] keep, rem, half;
      keep = v >> sh;
      rem  = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      return keep;
   endfunction

   function automatic logic [31:0] int_to_single(input logic sign, input logic [63:0] mag);
      int p;
      logic [7:0] ex;
      logic [63:0] keep;
      if (mag == 64'd0) return F32_ZERO;
      p = 63;
      while (!mag[p]) p--;
      ex = 8'(p + 127);
      if (p <= 23) keep = mag << (23 - p);
      else begin
         keep = rne_shift(mag, p - 23);
         if (keep == (64'd1 << 24)) begin
            keep = keep >> 1;
            ex = ex + 8'd1;
         end
      end
      return {sign, ex, keep[22:0]};
   endfunction

   function automatic logic [31:0] twos_to_single(input logic [63:0] v, input int w);
      logic [63:0] mask;
      mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      v = v & mask;
      if (v[w-1]) return int_to_single(1'b1, (~v + 64'd1) & mask);
      return int_to_single(1'b0, v);
   endfunction

   function automatic logic [31:0] double_to_single(input logic [63:0] d);
      logic s;
      logic [10:0] e;
      logic [51:0] f;
      logic [63:0] m, keep;
      int ex, sh;
      s = d[63];
      e = d[62:52];
      f = d[51:0];
      if (e == 11'h7FF) begin
         if (f == 0) return {s, F32_INF};
         return {s, F32_QNAN | {8'd0, f[51:29]}};
      end
      if (e == 0) return {s, 31'd0};
      m = {12'd1, f};
      ex = int'(e) - 1023;
      if (ex > 127) return {s, F32_INF};
      if (ex >= -126) begin
         keep = rne_shift(m, 29);
         if (keep == (64'd1 << 24)) begin
            keep = keep >> 1;
            ex++;
         end
         if (ex > 127) return {s, F32_INF};
         return {s, 8'(ex + 127), keep[22:0]};
      end
      sh = -ex - 97;
      if (sh > 60) return {s, 31'd0};
      keep = rne_shift(m, sh);
      return {s, 7'd0, keep[23:0]};
   endfunction

   function automatic logic [31:0] convert_value(input logic [3:0] op, input logic [63:0] vb,
                                                 input logic [7:0] len);
      if (len == 0) return F32_ZERO;
      case (op)
         OP_U8:  return int_to_single(1'b0, {56'd0, vb[63:56]});
         OP_I8:  return twos_to_single({56'd0, vb[63:56]}, 8);
         OP_U16: return (len >= 2) ? int_to_single(1'b0, {48'd0, vb[63:48]}) : F32_ZERO;
         OP_I16: return (len >= 2) ? twos_to_single({48'd0, vb[63:48]}, 16) : F32_ZERO;
         OP_U32: return (len >= 4) ? int_to_single(1'b0, {32'd0, vb[63:32]}) : F32_ZERO;
         OP_I32: return (len >= 4) ? twos_to_single({32'd0, vb[63:32]}, 32) : F32_ZERO;
         OP_U64: return (len >= 8) ? int_to_single(1'b0, vb) : F32_ZERO;
         OP_I64: return (len >= 8) ? twos_to_single(vb, 64) : F32_ZERO;
         OP_F32: return (len >= 4) ? vb[63:32] : F32_ZERO;
         OP_F64: return (len >= 8) ? double_to_single(vb) : F32_ZERO;
         default: return F32_ZERO;
      endcase
   endfunction

   assign pending = expected_bits.size();

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         expected_bits.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bits.size() == 0) begin
               $display("%0t: unexpected item, got %h", $time, rsp_float_bits);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_bits.pop_front();
               if (want !== rsp_float_bits) begin
                  $display("%0t: float_bits expected %h got %h", $time, want, rsp_float_bits);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            expected_bits.push_back(convert_value(req_op, req_value_bytes, req_byte_count));
      end
   end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import tvf_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [3:0]  req_op = '0;
   logic [63:0] req_value_bytes = '0;
   logic [7:0]  req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_float_bits;
   int          fail_count;
   int          pending;
   logic        stimulus_done = 0;

   always #1 clock = ~clock;

   typed_value_to_float32 uut (.*);

   tvf_scoreboard check (.*);

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // present one item and hold it until accepted
   task automatic send_item(input logic [3:0] op, input logic [63:0] vb, input logic [7:0] len);
      int g;
      g = gap_length();
      repeat (g) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_value_bytes  <= vb;
      req_byte_count   <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // random double bits, biased toward the single range edges and specials
   function automatic logic [63:0] pick_double();
      logic [63:0] d;
      int r;
      d = {$urandom, $urandom};
      r = $urandom_range(0, 9);
      case (r)
         0: d[62:52] = 11'h7FF;
         1: d[62:52] = 11'd0;
         2: d[62:52] = 11'($urandom_range(1023 + 120, 1023 + 130));
         3: d[62:52] = 11'($urandom_range(1023 - 160, 1023 - 120));
         4: d[28:0] = {1'b1, 28'd0};
         5: d[28:0] = '1;
         default: d[62:52] = 11'($urandom_range(1023 - 140, 1023 + 140));
      endcase
      return d;
   endfunction

   // receiver side stalls at random
   initial begin
      @(negedge reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         repeat (gap_length()) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [3:0]  op;
      logic [63:0] vb;
      logic [7:0]  len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: absent buffer, short lengths, unknown types, extremes
      send_item(OP_U8, '1, 8'd0);
      send_item(OP_U8, '1, 8'd1);
      send_item(OP_I8, 64'h80 << 56, 8'd1);
      send_item(OP_U16, '1, 8'd1);
      send_item(OP_I16, 64'h8000 << 48, 8'd2);
      send_item(OP_U32, '1, 8'd4);
      send_item(OP_I32, 64'h8000_0001 << 32, 8'd3);
      send_item(OP_I32, 64'h8000_0000 << 32, 8'd4);
      send_item(OP_U64, '1, 8'd8);
      send_item(OP_I64, 64'h8000_0000_0000_0000, 8'd255);
      send_item(OP_U64, 64'h0000_0000_0100_0001, 8'd8);  // tie to even, down
      send_item(OP_U64, 64'h0000_0000_0100_0003, 8'd8);  // tie to even, up
      send_item(OP_I64, 64'd0, 8'd8);
      send_item(OP_F32, 64'hFFFF_FFFF_0000_0000, 8'd4);
      send_item(OP_F64, 64'h7FF8_0000_0000_0001, 8'd8);  // NaN
      send_item(OP_F64, 64'hFFF0_0000_0000_0000, 8'd8);  // -inf
      send_item(OP_F64, 64'h47EF_FFFF_F000_0000, 8'd8);  // rounds to overflow
      send_item(OP_F64, 64'h8000_0000_0000_0001, 8'd8);  // double subnormal
      send_item(OP_F64, 64'h3800_0000_0000_0000, 8'd8);  // tiny normal
      send_item(OP_F64, 64'hB690_0000_0000_0000, 8'd8);  // rounds to zero
      send_item(OP_F64, 64'h3FF0_0000_0000_0000, 8'd7);
      send_item(OP_NONE, '1, 8'd8);
      send_item(4'd15, '1, 8'd8);
      send_item(4'd11, '1, 8'd8);

      // hold off until the pipe has drained
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      repeat (400) begin
         op = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 9) < 8) op = 4'($urandom_range(1, 10));
         vb = {$urandom, $urandom};
         if ($urandom_range(0, 3) == 0) vb = vb >> $urandom_range(0, 63);
         if (op == OP_F64) vb = pick_double();
         len = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
         send_item(op, vb, len);
      end
      req_valid <= 1'b0;
      stimulus_done <= 1'b1;
   end

   initial begin
      @(posedge stimulus_done);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
